// ----- design/corner_index_dedup_table_defines.svh -----
// Assertion macros for the corner index deduplication table.
`ifndef CORNER_INDEX_DEDUP_TABLE_DEFINES_SVH
`define CORNER_INDEX_DEDUP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held low.
`define CIDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("corner index dedup table: assertion failed");

// Next-cycle implication, disabled while reset is held low.
`define CIDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("corner index dedup table: assertion failed");

`endif

// ----- design/cidt_pkg.sv -----
// Package with widths and codes shared by the corner index deduplication table.
package cidt_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int IDX_W   = 17;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int KEY_W   = 3 * IDX_W;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

endpackage

// ----- design/corner_index_dedup_table.sv -----
// Top level of the corner index deduplication table.
//
// Input channel (i_in_valid / o_in_ready) carries one item: a command and a
// triple of position, texture and normal indices. A lookup item scans the
// stored triples in insertion order, one memory read per cycle, and answers
// with the matching slot, or appends the triple and answers with the new
// slot, or flags overflow with slot zero when the table is full. A clear
// item empties the table and gives no result.
// Output channel (o_out_valid / i_out_ready) carries slot, is_new, overflow
// and entry_count from an output register.
// The time to a lookup result is set by the scan over the single read port
// of the triple memory; the next item is taken once the result is loaded
// into the output register.
// A new item is accepted while a result still waits in the output register;
// a finished lookup holds in its final state until that register is free.
// Reset empties the table (fill count to zero) and drops any pending result;
// the memory contents are not cleared.
`include "corner_index_dedup_table_defines.svh"

module corner_index_dedup_table #(
    parameter int TABLE_DEPTH = cidt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic signed [cidt_pkg::IDX_W-1:0]   i_position_index,
    input  logic signed [cidt_pkg::IDX_W-1:0]   i_texture_index,
    input  logic signed [cidt_pkg::IDX_W-1:0]   i_normal_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cidt_pkg::SLOT_W-1:0]         o_slot,
    output logic                                o_is_new,
    output logic                                o_overflow,
    output logic [cidt_pkg::COUNT_W-1:0]        o_entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [cidt_pkg::KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]              r_fill, n_fill;
    logic [CW-1:0]              r_issue, n_issue;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]              r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]              r_res_slot, n_res_slot;
    logic                       r_res_new, n_res_new;
    logic                       r_res_ovf, n_res_ovf;

    logic                       r_out_valid, n_out_valid;
    logic [cidt_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic                       r_is_new, n_is_new;
    logic                       r_overflow, n_overflow;
    logic [cidt_pkg::COUNT_W-1:0] r_count, n_count;

    logic                       in_fire;
    logic                       out_free;
    logic                       hit;
    logic                       scan_done;
    logic [CW-1:0]              fill_inc;
    logic                       rd_en;
    logic                       wr_en;
    logic [cidt_pkg::KEY_W-1:0] rd_data;

    cidt_ram #(
        .WIDTH (cidt_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_triple_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_res_slot),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign hit        = r_cmp_vld && (rd_data == r_key);
    assign scan_done  = !hit && (r_issue == r_fill);
    assign fill_inc   = r_fill + CW'(1);
    assign rd_en      = (r_state == ST_SEARCH) && (r_issue != r_fill);
    assign wr_en      = (r_state == ST_FINISH) && out_free && r_res_new;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_fill      = r_fill;
        n_issue     = r_issue;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_res_slot  = r_res_slot;
        n_res_new   = r_res_new;
        n_res_ovf   = r_res_ovf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_slot      = r_slot;
        n_is_new    = r_is_new;
        n_overflow  = r_overflow;
        n_count     = r_count;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_command == cidt_pkg::CMD_CLEAR) begin
                        n_fill = '0;
                    end else begin
                        n_key     = {i_position_index, i_texture_index, i_normal_index};
                        n_issue   = '0;
                        n_cmp_vld = 1'b0;
                        n_state   = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    n_res_slot = r_cmp_idx;
                    n_res_new  = 1'b0;
                    n_res_ovf  = 1'b0;
                    n_state    = ST_FINISH;
                end else if (scan_done) begin
                    if (r_fill < CW'(TABLE_DEPTH)) begin
                        n_res_slot = r_fill[AW-1:0];
                        n_res_new  = 1'b1;
                        n_res_ovf  = 1'b0;
                    end else begin
                        n_res_slot = '0;
                        n_res_new  = 1'b0;
                        n_res_ovf  = 1'b1;
                    end
                    n_state = ST_FINISH;
                end else begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_issue[AW-1:0];
                    n_issue   = r_issue + CW'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_slot      = cidt_pkg::SLOT_W'(r_res_slot);
                    n_is_new    = r_res_new;
                    n_overflow  = r_res_ovf;
                    if (r_res_new) begin
                        n_fill  = fill_inc;
                        n_count = cidt_pkg::COUNT_W'(fill_inc);
                    end else begin
                        n_count = cidt_pkg::COUNT_W'(r_fill);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_issue    <= n_issue;
        r_cmp_idx  <= n_cmp_idx;
        r_res_slot <= n_res_slot;
        r_res_new  <= n_res_new;
        r_res_ovf  <= n_res_ovf;
        r_slot     <= n_slot;
        r_is_new   <= n_is_new;
        r_overflow <= n_overflow;
        r_count    <= n_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_slot;
    assign o_is_new      = r_is_new;
    assign o_overflow    = r_overflow;
    assign o_entry_count = r_count;

    `CIDT_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(TABLE_DEPTH))
    `CIDT_ASSERT_IMPL(a_ovf_result, i_clk, i_rst_n, o_out_valid && o_overflow,
        !o_is_new && (o_slot == '0))
    `CIDT_ASSERT_NEXT(a_write_grows, i_clk, i_rst_n, wr_en, r_fill == $past(fill_inc))
    `CIDT_ASSERT_NEXT(a_lookup_starts, i_clk, i_rst_n,
        in_fire && (i_command == cidt_pkg::CMD_LOOKUP), r_state == ST_SEARCH)

endmodule

// ----- design/cidt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cidt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
